// ===== src/sme_pkg.sv =====
`timescale 1ns / 1ps

package sme_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH     = 3'd0,
      ACT_ADD      = 3'd1,
      ACT_MUL      = 3'd2,
      ACT_OUT      = 3'd3,
      ACT_PUSH_ACC = 3'd4,
      ACT_POP_ACC  = 3'd5,
      ACT_JUMP     = 3'd6,
      ACT_INVALID  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_BAD_OP    = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] immediate;
      logic [15:0]        target;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic               jump_taken;
      logic [15:0]        jump_dest;
      logic [4:0]         stack_level;
   } rsp_type;

   // Classified instruction as it waits between the front and back parts.
   typedef struct packed {
      action_type         op;
      logic               pushes;
      logic               pops_one;
      logic               pops_two;
      logic signed [31:0] immediate;
      logic [15:0]        target;
   } cmd_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/stack_machine_executor.sv =====
`timescale 1ns / 1ps

// Stack-machine executor. Each transfer on the req_ channel carries one
// instruction (action, immediate, target); each instruction yields exactly one
// transfer on the rsp_ channel with its status, any value popped by out, the
// jump outcome and the stack level afterwards, in instruction order.
// Both channels use valid/ready. A front decoder classifies instructions into
// a two-entry queue; the back end runs them against a register-topped operand
// stack whose lower entries sit in a memory with read-ahead of two entries.
// Each request is registered in the queue and each response in an output register.
// Throughput is one instruction per cycle while rsp_ready stays high; a
// multiply stalls the back end to register its partial products before the sum.
// Reset empties the stack and the queue, clears the accumulator and drops any
// pending response. When the receiver holds rsp_ready low the response stays
// put, the back end stops, the queue fills and then req_ready falls.
module stack_machine_executor
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic          queue_full;
   logic          queue_push;
   cmd_type       queue_cmd;
   logic          head_valid;
   cmd_type       head_cmd;
   logic          head_pop;
   logic [CW-1:0] stack_count;

   sme_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_cmd  (queue_cmd)
   );

   sme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (queue_cmd),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sme_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .stack_count (stack_count)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count <= CW'(STACK_DEPTH))
      else $error("stack count above depth");

   a_jump_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.jump_taken |-> rsp_data.status == ST_OK && !rsp_data.out_valid)
      else $error("taken jump with bad status or popped value");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (stack_count == $past(stack_count))
                     || (stack_count == $past(stack_count) + 1'b1)
                     || (stack_count + 1'b1 == $past(stack_count))
                     || (stack_count + CW'(2) == $past(stack_count)))
      else $error("stack count moved by more than one instruction allows");
`endif

endmodule

// ===== src/sme_front.sv =====
`timescale 1ns / 1ps

module sme_front
   import sme_pkg::*;
(
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    queue_push,
   output cmd_type queue_cmd
);

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      queue_cmd.op        = req_data.action;
      queue_cmd.immediate = req_data.immediate;
      queue_cmd.target    = req_data.target;
      queue_cmd.pushes    = 1'b0;
      queue_cmd.pops_one  = 1'b0;
      queue_cmd.pops_two  = 1'b0;
      unique case (req_data.action)
         ACT_PUSH, ACT_PUSH_ACC: begin
            queue_cmd.pushes = 1'b1;
         end
         ACT_ADD, ACT_MUL, ACT_JUMP: begin
            queue_cmd.pops_two = 1'b1;
         end
         ACT_OUT, ACT_POP_ACC: begin
            queue_cmd.pops_one = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/sme_queue.sv =====
`timescale 1ns / 1ps

module sme_queue
   import sme_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   fill_ff, fill_in;
   logic                  do_pop;

   assign full       = (fill_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/sme_back.sv =====
`timescale 1ns / 1ps

module sme_back
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int DATA_WIDTH  = 32,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   output logic [CW-1:0] stack_count
);

   localparam int AW     = $clog2(STACK_DEPTH);
   localparam int MUL_LO = (DATA_WIDTH + 1) / 2;
   localparam int MUL_HI = DATA_WIDTH - MUL_LO;

   // Top two entries live in registers; the rest sit in the memory, and the two
   // entries just below the top pair are read ahead into q0_ff and q1_ff.
   logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] q0_ff, q1_ff;
   logic [DATA_WIDTH-1:0] t0_ff, t0_in;
   logic [DATA_WIDTH-1:0] t1_ff, t1_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  mem_we;
   logic [AW-1:0]         wr_addr, rd0_addr, rd1_addr;

   logic [2*MUL_LO-1:0]        mul_lo_ff, mul_lo_in;
   logic [MUL_HI-1:0]          mul_x1_ff, mul_x2_ff;
   logic [MUL_LO+MUL_HI-1:0]   mul_x1_full, mul_x2_full;
   logic [MUL_HI-1:0]          cross_sum;
   logic [DATA_WIDTH-1:0]      product;
   logic                       mul_phase_ff, mul_phase_in;
   logic                       mul_wait, mul_start;

   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free, fire;
   logic [DATA_WIDTH-1:0] push_value;
   logic                  has_one, has_two, is_full;

   assign has_one = (count_ff != '0);
   assign has_two = (count_ff >= CW'(2));
   assign is_full = (count_ff == CW'(STACK_DEPTH));

   // Multiply is split into partial products registered at mul_start and summed
   // when the instruction completes, after mul_phase_ff is set.
   assign mul_wait  = (cmd.op == ACT_MUL) && has_two && !mul_phase_ff;
   assign mul_start = cmd_valid && mul_wait;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = cmd_valid && out_free && !mul_wait;
   assign cmd_pop   = fire;

   assign mul_lo_in   = t0_ff[MUL_LO-1:0] * t1_ff[MUL_LO-1:0];
   assign mul_x1_full = t0_ff[MUL_LO-1:0] * t1_ff[DATA_WIDTH-1:MUL_LO];
   assign mul_x2_full = t0_ff[DATA_WIDTH-1:MUL_LO] * t1_ff[MUL_LO-1:0];
   assign cross_sum   = mul_x1_ff + mul_x2_ff;
   assign product     = mul_lo_ff[DATA_WIDTH-1:0] + {cross_sum, {MUL_LO{1'b0}}};

   assign push_value = (cmd.op == ACT_PUSH_ACC) ? acc_ff : DATA_WIDTH'(cmd.immediate);

   always_comb begin
      count_in     = count_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      mem_we       = 1'b0;
      mul_phase_in = mul_phase_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (mul_start) begin
         mul_phase_in = 1'b1;
      end
      if (fire) begin
         mul_phase_in       = 1'b0;
         rsp_valid_in       = 1'b1;
         rsp_in.status      = ST_OK;
         rsp_in.out_valid   = 1'b0;
         rsp_in.out_value   = '0;
         rsp_in.jump_taken  = 1'b0;
         rsp_in.jump_dest   = '0;
         if (cmd.pushes) begin
            if (is_full) begin
               rsp_in.status = ST_OVERFLOW;
            end else begin
               mem_we   = has_two;
               t1_in    = t0_ff;
               t0_in    = push_value;
               count_in = count_ff + 1'b1;
            end
         end else if (cmd.pops_two) begin
            if (!has_two) begin
               rsp_in.status = ST_UNDERFLOW;
            end else if (cmd.op == ACT_JUMP) begin
               t0_in    = q0_ff;
               t1_in    = q1_ff;
               count_in = count_ff - CW'(2);
               if ($signed(t0_ff) > $signed(t1_ff)) begin
                  rsp_in.jump_taken = 1'b1;
                  rsp_in.jump_dest  = cmd.target;
               end
            end else begin
               t0_in    = (cmd.op == ACT_MUL) ? product : t0_ff + t1_ff;
               t1_in    = q0_ff;
               count_in = count_ff - 1'b1;
            end
         end else if (cmd.pops_one) begin
            if (!has_one) begin
               rsp_in.status = ST_UNDERFLOW;
            end else begin
               t0_in    = t1_ff;
               t1_in    = q0_ff;
               count_in = count_ff - 1'b1;
               if (cmd.op == ACT_POP_ACC) begin
                  acc_in = t0_ff;
               end else begin
                  rsp_in.out_valid = 1'b1;
                  rsp_in.out_value = 32'(t0_ff);
               end
            end
         end else begin
            rsp_in.status = ST_BAD_OP;
         end
         rsp_in.stack_level = 5'(count_in);
      end
   end

   // A push spills the old second entry to the slot that becomes the first
   // read-ahead entry, so that read takes the write data directly.
   assign wr_addr  = AW'(count_ff - CW'(2));
   assign rd0_addr = AW'(count_in - CW'(3));
   assign rd1_addr = AW'(count_in - CW'(4));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= t1_ff;
      end
      if (mem_we && (wr_addr == rd0_addr)) begin
         q0_ff <= t1_ff;
      end else begin
         q0_ff <= stack_mem[rd0_addr];
      end
      if (mem_we && (wr_addr == rd1_addr)) begin
         q1_ff <= t1_ff;
      end else begin
         q1_ff <= stack_mem[rd1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         acc_ff       <= '0;
         mul_phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         mul_phase_ff <= mul_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      rsp_ff <= rsp_in;
      if (mul_start) begin
         mul_lo_ff <= mul_lo_in;
         mul_x1_ff <= mul_x1_full[MUL_HI-1:0];
         mul_x2_ff <= mul_x2_full[MUL_HI-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign stack_count = count_ff;

endmodule
